[src/itzf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itzf_pkg
// Types and constants shared by the image translate and zero fill block.
// ----------------------------------------------------------------------------
package itzf_pkg;

  localparam int PIXEL_W    = 8;
  localparam int DIM_REG_W  = 7;
  localparam int SHIFT_W    = 8;
  localparam int APB_DATA_W = 32;
  localparam int REG_ADDR_W = 4;

  localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 7'd64;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    REG_HEIGHT  = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_SHIFT_Y = 2'd2,
    REG_SHIFT_X = 2'd3
  } reg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic               command;
    logic [PIXEL_W-1:0] pixel_in;
  } cmd_word_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               frame_last;
  } pix_word_t;

  typedef struct packed {
    logic [DIM_REG_W-1:0]      height;
    logic [DIM_REG_W-1:0]      width;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [SHIFT_W-1:0] shift_x;
  } cfg_regs_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_ready;
    logic slot_free;
  } dp_status_t;

endpackage

[src/itzf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itzf_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module itzf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/itzf_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itzf_regs
// APB register file holding frame dimensions and shift offsets.
// ----------------------------------------------------------------------------
module itzf_regs import itzf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  reg_index_t reg_idx;

  assign reg_idx = reg_index_t'(paddr[REG_ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height  <= HEIGHT_RESET;
      cfg.width   <= WIDTH_RESET;
      cfg.shift_y <= '0;
      cfg.shift_x <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_HEIGHT:  cfg.height  <= pwdata[DIM_REG_W-1:0];
        REG_WIDTH:   cfg.width   <= pwdata[DIM_REG_W-1:0];
        REG_SHIFT_Y: cfg.shift_y <= $signed(pwdata[SHIFT_W-1:0]);
        REG_SHIFT_X: cfg.shift_x <= $signed(pwdata[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEIGHT:  prdata = APB_DATA_W'(cfg.height);
      REG_WIDTH:   prdata = APB_DATA_W'(cfg.width);
      REG_SHIFT_Y: prdata = APB_DATA_W'($unsigned(cfg.shift_y));
      REG_SHIFT_X: prdata = APB_DATA_W'($unsigned(cfg.shift_x));
      default:     prdata = '0;
    endcase
  end

endmodule

[src/itzf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itzf_ctrl
// Controller: accepts commands and sequences the frame store read for fetches.
// ----------------------------------------------------------------------------
module itzf_ctrl import itzf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       command,
  input  dp_status_t status,
  output logic       cmd_stall,
  output ctrl_cmd_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (command == CMD_LOAD) begin
            ctl.load = 1'b1;
          end else if (status.frame_ready) begin
            // A fetch before the frame is complete is dropped.
            ctl.fetch  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Read data is held by the RAM until the output slot frees up.
        if (status.slot_free) begin
          ctl.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[src/itzf_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itzf_dpath
// Datapath: raster counters, frame store, source address and output register.
// ----------------------------------------------------------------------------
module itzf_dpath import itzf_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_regs_t          cfg,
  input  ctrl_cmd_t          ctl,
  input  logic [PIXEL_W-1:0] pixel_in,
  input  logic               pix_stall,
  output dp_status_t         status,
  output logic               pix_valid,
  output pix_word_t          pix_word
);

  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int POSW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int XW    = (DIMW > DIM_REG_W) ? DIMW : DIM_REG_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = ((POSW > SHIFT_W) ? POSW : SHIFT_W) + 2;

  function automatic logic [DIMW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [DIMW-1:0] r;
    if (v == '0) begin
      r = DIMW'(1);
    end else if (XW'(v) > XW'(MAX_DIM)) begin
      r = DIMW'(MAX_DIM);
    end else begin
      r = DIMW'(v);
    end
    return r;
  endfunction

  logic [DIMW-1:0] h, w;
  logic [POSW-1:0] load_row, load_col, out_row, out_col;
  logic            frame_ready;
  logic            pend_inside, pend_last;

  logic [POSW-1:0] ld_row0, ld_col0, ld_row, ld_col;
  logic            ld_col_wrap, ld_row_wrap;
  logic [POSW-1:0] ft_row, ft_col;
  logic            ft_col_wrap, ft_row_wrap;
  logic signed [SW-1:0] src_row, src_col;
  logic            ft_inside, ft_last;

  logic [AW-1:0]      waddr, raddr;
  logic [PIXEL_W-1:0] rdata;

  assign h = clamp_dim(cfg.height);
  assign w = clamp_dim(cfg.width);

  // Load position: a load on a finished frame starts over at the origin, and a
  // position left outside shrunken dimensions restarts too.
  always_comb begin
    ld_row0 = frame_ready ? '0 : load_row;
    ld_col0 = frame_ready ? '0 : load_col;
    if (DIMW'(ld_row0) >= h || DIMW'(ld_col0) >= w) begin
      ld_row = '0;
      ld_col = '0;
    end else begin
      ld_row = ld_row0;
      ld_col = ld_col0;
    end
    ld_col_wrap = (DIMW'(ld_col) + DIMW'(1) >= w);
    ld_row_wrap = (DIMW'(ld_row) + DIMW'(1) >= h);
  end

  // Fetch position and the source pixel it maps to.
  always_comb begin
    if (DIMW'(out_row) >= h || DIMW'(out_col) >= w) begin
      ft_row = '0;
      ft_col = '0;
    end else begin
      ft_row = out_row;
      ft_col = out_col;
    end
    ft_col_wrap = (DIMW'(ft_col) + DIMW'(1) >= w);
    ft_row_wrap = (DIMW'(ft_row) + DIMW'(1) >= h);
    ft_last     = (DIMW'(ft_row) + DIMW'(1) == h) && (DIMW'(ft_col) + DIMW'(1) == w);
    src_row     = SW'($signed({1'b0, ft_row})) - SW'(cfg.shift_y);
    src_col     = SW'($signed({1'b0, ft_col})) - SW'(cfg.shift_x);
    ft_inside   = (src_row >= 0) && (src_row < $signed(SW'(h))) &&
                  (src_col >= 0) && (src_col < $signed(SW'(w)));
  end

  assign waddr = AW'(ld_row) * AW'(MAX_DIM) + AW'(ld_col);
  assign raddr = AW'(src_row[POSW-1:0]) * AW'(MAX_DIM) + AW'(src_col[POSW-1:0]);

  itzf_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.load),
    .waddr (waddr),
    .wdata (pixel_in),
    .re    (ctl.fetch),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      load_row    <= '0;
      load_col    <= '0;
      out_row     <= '0;
      out_col     <= '0;
      frame_ready <= 1'b0;
      pix_valid   <= 1'b0;
    end else begin
      if (ctl.load) begin
        // The frame is ready only after the load that fills its last pixel.
        // The fetch position only moves while a frame is ready and restarts
        // with every new frame, so any load returns it to the origin.
        frame_ready <= ld_col_wrap && ld_row_wrap;
        out_row     <= '0;
        out_col     <= '0;
        if (ld_col_wrap) begin
          load_col <= '0;
          load_row <= ld_row_wrap ? '0 : ld_row + POSW'(1);
        end else begin
          load_row <= ld_row;
          load_col <= ld_col + POSW'(1);
        end
      end
      if (ctl.fetch) begin
        if (ft_col_wrap) begin
          out_col <= '0;
          out_row <= ft_row_wrap ? '0 : ft_row + POSW'(1);
        end else begin
          out_row <= ft_row;
          out_col <= ft_col + POSW'(1);
        end
      end
      if (ctl.emit) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      pend_inside <= ft_inside;
      pend_last   <= ft_last;
    end
    if (ctl.emit) begin
      pix_word.pixel_out  <= pend_inside ? rdata : '0;
      pix_word.frame_last <= pend_last;
    end
  end

  assign status.frame_ready = frame_ready;
  assign status.slot_free   = !pix_valid || !pix_stall;

endmodule

[src/image_translate_zero_fill_core.sv]
`timescale 1ns / 1ps
// A load word is taken in the idle state and gives no result. A fetch word is
// read from the frame store and waits in the read state until the output
// register is free; pix_valid rises once the pixel is written there.
// One load per cycle while idle; a fetch holds off all commands until then.
// Reset: counters, frame-ready flag, controller and output valid clear, the
// registers return to 64 x 64 with zero shift; the frame store is not cleared.
// ----------------------------------------------------------------------------
// image_translate_zero_fill_core
// Frame store that replays a loaded grayscale frame shifted by a signed row
// and column offset, filling uncovered pixels with black.
// ----------------------------------------------------------------------------
module image_translate_zero_fill_core import itzf_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command channel: loads and fetches.
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_word_t             cmd_word,
  // Pixel result channel.
  output logic                  pix_valid,
  input  logic                  pix_stall,
  output pix_word_t             pix_word,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_regs_t  cfg;
  ctrl_cmd_t  ctl;
  dp_status_t status;

  // The user must change the register file only while the block is idle;
  // the block does not enforce it. The datapath reads it with no shadow copy.
  itzf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller takes one command word at a time. A fetch parks it in the
  // read state until the output register can take the looked-up pixel.
  itzf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd_word.command),
    .status    (status),
    .cmd_stall (cmd_stall),
    .ctl       (ctl)
  );

  // The datapath keeps the raster counters, computes the source address of
  // each output pixel, and owns the frame store and the output register.
  itzf_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (ctl),
    .pixel_in  (cmd_word.pixel_in),
    .pix_stall (pix_stall),
    .status    (status),
    .pix_valid (pix_valid),
    .pix_word  (pix_word)
  );

  // A fetch that was started holds off the command channel in the next cycle.
  a_fetch_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.fetch |=> cmd_stall)
    else $error("command accepted while a fetch read was outstanding");

  // The output register is never overwritten while a word waits in it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !(pix_valid && pix_stall))
    else $error("pixel emitted over a stalled word");

  // Every emitted pixel shows up on the result channel.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> pix_valid)
    else $error("emitted pixel did not raise pix_valid");

  // An emit only ever follows a fetch that was accepted earlier.
  a_emit_after_fetch: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> cmd_stall)
    else $error("pixel emitted without an outstanding fetch");

endmodule

[bench/tb_image_translate_zero_fill_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_translate_zero_fill_core
// Self-checking bench for the frame translate and zero fill core. Frames are
// loaded and fetched through the command channel under many sizes and shifts
// programmed over the configuration port. Every pixel word that comes back is
// compared with the word predicted by an independent model of the frame store.
// ----------------------------------------------------------------------------
module tb_image_translate_zero_fill_core;
  import itzf_pkg::*;

  localparam int STORE_DIM    = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_TAIL    = 6;
  localparam int REPORT_LIMIT = 10;

  // The scoreboard keeps its own copy of the frame store, the load and fetch
  // positions and the four registers. Each accepted command word is run
  // through it, and every fetch of a ready frame leaves one predicted pixel
  // word in the queue. It also remembers which store entries were written, so
  // that the stimulus never makes the core read an entry it never stored.
  class frame_shift_scoreboard;
    logic [PIXEL_W-1:0]        store [STORE_DIM*STORE_DIM];
    bit                        written [STORE_DIM*STORE_DIM];
    int unsigned               load_row, load_col, out_row, out_col;
    bit                        frame_ready;
    logic [DIM_REG_W-1:0]      height_reg, width_reg;
    logic signed [SHIFT_W-1:0] shift_y_reg, shift_x_reg;
    pix_word_t                 expected_pixels [$];
    int                        errors, reported;

    function new();
      load_row    = 0;
      load_col    = 0;
      out_row     = 0;
      out_col     = 0;
      frame_ready = 1'b0;
      height_reg  = HEIGHT_RESET;
      width_reg   = WIDTH_RESET;
      shift_y_reg = '0;
      shift_x_reg = '0;
      errors      = 0;
      reported    = 0;
    endfunction

    // A size of zero acts as one row or column, anything above the store
    // dimension acts as the full dimension.
    function int unsigned eff_dim(logic [DIM_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > STORE_DIM) return STORE_DIM;
      return v;
    endfunction

    function void set_reg(reg_index_t idx, logic [APB_DATA_W-1:0] data);
      case (idx)
        REG_HEIGHT:  height_reg  = data[DIM_REG_W-1:0];
        REG_WIDTH:   width_reg   = data[DIM_REG_W-1:0];
        REG_SHIFT_Y: shift_y_reg = data[SHIFT_W-1:0];
        REG_SHIFT_X: shift_x_reg = data[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] reg_value(reg_index_t idx);
      case (idx)
        REG_HEIGHT:  return {1'b0, height_reg};
        REG_WIDTH:   return {1'b0, width_reg};
        REG_SHIFT_Y: return shift_y_reg;
        default:     return shift_x_reg;
      endcase
    endfunction

    // Source of the next fetched pixel; returns 0 when it falls outside the
    // frame and the pixel is black.
    function bit source_addr(output int unsigned addr);
      int unsigned h, w, r, c;
      int          sr, sc;
      h  = eff_dim(height_reg);
      w  = eff_dim(width_reg);
      r  = out_row;
      c  = out_col;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      sr   = int'(r) - int'(shift_y_reg);
      sc   = int'(c) - int'(shift_x_reg);
      addr = 0;
      if (sr < 0 || sr >= int'(h) || sc < 0 || sc >= int'(w)) return 1'b0;
      addr = sr * STORE_DIM + sc;
      return 1'b1;
    endfunction

    function bit fetch_hazard();
      int unsigned addr;
      if (!frame_ready) return 1'b0;
      if (source_addr(addr)) return !written[addr];
      return 1'b0;
    endfunction

    // Number of loads that finish the frame now being loaded, or a whole new
    // frame when one is ready.
    function int unsigned loads_to_complete();
      int unsigned h, w, r, c;
      h = eff_dim(height_reg);
      w = eff_dim(width_reg);
      if (frame_ready) return h * w;
      r = load_row;
      c = load_col;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      return h * w - (r * w + c);
    endfunction

    function void predict_word(cmd_word_t word);
      int unsigned h, w, addr;
      bit          hit;
      pix_word_t   pix;
      h = eff_dim(height_reg);
      w = eff_dim(width_reg);
      if (word.command == CMD_LOAD) begin
        // A load on a ready frame starts the next frame from the corner.
        if (frame_ready) begin
          frame_ready = 1'b0;
          load_row    = 0;
          load_col    = 0;
          out_row     = 0;
          out_col     = 0;
        end
        if (load_row >= h || load_col >= w) begin
          load_row = 0;
          load_col = 0;
        end
        addr          = load_row * STORE_DIM + load_col;
        store[addr]   = word.pixel_in;
        written[addr] = 1'b1;
        if (load_col + 1 >= w) begin
          load_col = 0;
          if (load_row + 1 >= h) begin
            load_row    = 0;
            frame_ready = 1'b1;
            out_row     = 0;
            out_col     = 0;
          end else begin
            load_row++;
          end
        end else begin
          load_col++;
        end
      end else if (frame_ready) begin
        if (out_row >= h || out_col >= w) begin
          out_row = 0;
          out_col = 0;
        end
        hit            = source_addr(addr);
        pix.pixel_out  = hit ? store[addr] : '0;
        pix.frame_last = (out_row + 1 == h) && (out_col + 1 == w);
        expected_pixels.push_back(pix);
        if (out_col + 1 >= w) begin
          out_col = 0;
          if (out_row + 1 >= h) out_row = 0;
          else out_row++;
        end else begin
          out_col++;
        end
      end
    endfunction

    function void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
      errors++;
      if (reported < REPORT_LIMIT) begin
        reported++;
        $display("mismatch in %s: expected %0h, got %0h", what, exp_v, got_v);
      end
    endfunction

    function void check_pixel(pix_word_t got);
      pix_word_t exp_word;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("pixel word %0h arrived with nothing predicted", got);
        end
      end else begin
        exp_word = expected_pixels.pop_front();
        if (got.pixel_out !== exp_word.pixel_out)
          note_mismatch("pixel_out", exp_word.pixel_out, got.pixel_out);
        if (got.frame_last !== exp_word.frame_last)
          note_mismatch("frame_last", exp_word.frame_last, got.frame_last);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  // Every input of the core starts at a known level; reset is held from time
  // zero until the stimulus process releases it.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_word_t             cmd_word  = '0;
  logic                  pix_valid;
  logic                  pix_stall = 1'b0;
  pix_word_t             pix_word;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [REG_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  frame_shift_scoreboard pix_sb = new();

  // Counted stimulus, the sender idling switch for the current phase, and the
  // request for a long receiver hold-off that the sink process counts out.
  int items_sent   = 0;
  bit no_gaps      = 1'b1;
  bit hold_request = 1'b0;

  image_translate_zero_fill_core #(
    .MAX_DIM(STORE_DIM)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word (cmd_word),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_word (pix_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Sender gaps: mostly back to back, some short pauses and now and then a
  // long one. A phase may switch gaps off entirely.
  function automatic int sender_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver behavior comes in runs: free stretches, some long enough to give
  // full-rate traffic, and stalls that are mostly short with a few long ones.
  function automatic void pick_stall_run(output bit stall_next, output int run_left);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      stall_next = 1'b0;
      run_left   = $urandom_range(1, 12);
    end else if (r < 55) begin
      stall_next = 1'b0;
      run_left   = $urandom_range(40, 150);
    end else if (r < 85) begin
      stall_next = 1'b1;
      run_left   = $urandom_range(1, 3);
    end else if (r < 97) begin
      stall_next = 1'b1;
      run_left   = $urandom_range(4, 15);
    end else begin
      stall_next = 1'b1;
      run_left   = $urandom_range(30, 80);
    end
    run_left = run_left - 1;
  endfunction

  // Register code for an effective size: the size itself, or an out of range
  // code that the core must clamp to the same size.
  function automatic logic [DIM_REG_W-1:0] dim_code(int unsigned eff);
    int r;
    r = $urandom_range(0, 2);
    if (eff == 1 && r == 0) return '0;
    if (eff == STORE_DIM && r == 1) return 7'd127;
    if (eff == STORE_DIM && r == 2) return DIM_REG_W'($urandom_range(65, 126));
    return DIM_REG_W'(eff);
  endfunction

  // Shifts mostly stay within one pixel beyond the frame size, so both the
  // partly covered and the all-black cases come up; the rest are any byte.
  function automatic logic [SHIFT_W-1:0] pick_shift(int unsigned dim);
    int s;
    if ($urandom_range(0, 4) == 0) return SHIFT_W'($urandom_range(0, 255));
    s = int'($urandom_range(0, 2 * dim + 2)) - int'(dim + 1);
    return SHIFT_W'(s);
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready. A write
  // lands at the access edge, which is also where read data is sampled. The
  // extra edge at the end keeps two transfers from touching psel in one step.
  task automatic apb_access(input reg_index_t idx, input bit is_write,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Register write with random upper data bits, which the core must ignore,
  // and an occasional read back of the bits that the register keeps.
  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    logic [APB_DATA_W-1:0] data;
    logic [APB_DATA_W-1:0] rdata;
    logic [7:0]            mask;
    mask      = (idx == REG_HEIGHT || idx == REG_WIDTH) ? 8'h7F : 8'hFF;
    data      = $urandom();
    data[7:0] = (data[7:0] & ~mask) | (value & mask);
    apb_access(idx, 1'b1, data, rdata);
    pix_sb.set_reg(idx, data);
    if ($urandom_range(0, 2) == 0) begin
      apb_access(idx, 1'b0, $urandom(), rdata);
      if ((rdata[7:0] & mask) != (pix_sb.reg_value(idx) & mask))
        pix_sb.note_mismatch("register read back", pix_sb.reg_value(idx) & mask,
                             rdata[7:0] & mask);
    end
  endtask

  // Offer one command word and hold it until the core takes it. A fetch that
  // would read a store entry never loaded is turned into a load. The word is
  // fed to the scoreboard in this same process, so the next hazard check
  // always sees up to date state. Valid only drops when a gap follows.
  task automatic send_cmd(input cmd_code_t code, input logic [PIXEL_W-1:0] pixel);
    cmd_word_t word;
    int        gap;
    if (code == CMD_FETCH && pix_sb.fetch_hazard()) code = CMD_LOAD;
    if (code == CMD_LOAD || pix_sb.frame_ready) items_sent++;
    word.command  = code;
    word.pixel_in = pixel;
    cmd_valid <= 1'b1;
    cmd_word  <= word;
    do @(posedge clk); while (cmd_stall);
    pix_sb.predict_word(word);
    gap = sender_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A command of the intended kind, now and then replaced by a random one to
  // break the sequence.
  task automatic send_item(input cmd_code_t code, input bit noisy);
    if (noisy && $urandom_range(0, 39) == 0) code = cmd_code_t'($urandom_range(0, 1));
    send_cmd(code, PIXEL_W'($urandom_range(0, 255)));
  endtask

  // Quiet point: stop offering words, let every predicted pixel arrive, then
  // wait out an idle tail, since the last load has no result.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (pix_sb.pending() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // One random phase: at a quiet point possibly new registers, then usually
  // a complete frame load followed by one or two frame fetches, otherwise a
  // burst of random commands. The big phase loads and fetches one frame of
  // the full store height. A pressure phase always completes a frame load and
  // fetches enough words to back up into the command channel.
  task automatic run_phase(input bit big, input bit pressure);
    int unsigned h, w, n_loads, n_fetch;
    bit          dims_new;
    int          r;
    wait_idle();
    no_gaps  = ($urandom_range(0, 3) == 0);
    dims_new = big || ($urandom_range(0, 2) == 0);
    if (dims_new) begin
      r = $urandom_range(0, 19);
      if (big) begin
        h = STORE_DIM;
        w = STORE_DIM / 8;
      end else if (r == 0) begin
        h = STORE_DIM;
        w = 1;
      end else if (r == 1) begin
        h = 1;
        w = STORE_DIM;
      end else begin
        h = $urandom_range(1, 6);
        w = $urandom_range(1, 8);
      end
      write_reg(REG_HEIGHT, {1'b0, dim_code(h)});
      write_reg(REG_WIDTH, {1'b0, dim_code(w)});
    end else begin
      h = pix_sb.eff_dim(pix_sb.height_reg);
      w = pix_sb.eff_dim(pix_sb.width_reg);
    end
    if (dims_new || $urandom_range(0, 1) == 0) write_reg(REG_SHIFT_Y, pick_shift(h));
    if (dims_new || $urandom_range(0, 1) == 0) write_reg(REG_SHIFT_X, pick_shift(w));

    if (!big && !pressure && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(10, 30)) send_item(cmd_code_t'($urandom_range(0, 1)), 1'b0);
    end else begin
      n_loads = pix_sb.loads_to_complete();
      // With the same size and a frame still ready, sometimes just fetch it
      // again under the new shifts.
      if (pix_sb.frame_ready && !dims_new && !pressure && $urandom_range(0, 2) == 0)
        n_loads = 0;
      repeat (n_loads) send_item(CMD_LOAD, !big && !pressure);
      // The sink stalls for a long stretch while fetches keep coming, so the
      // core fills up and has to stall the command channel.
      if (pressure) hold_request = 1'b1;
      n_fetch = big ? h * w + 2 : h * w * $urandom_range(1, 2) + $urandom_range(0, 3);
      if (pressure) n_fetch = n_fetch + 4;
      repeat (n_fetch) send_item(CMD_FETCH, !big && !pressure);
    end
  endtask

  // Pixel sink: checks every accepted pixel word and drives pix_stall. A
  // hold-off request is counted out here, cycle by cycle.
  initial begin : pixel_sink
    int run_left  = 0;
    int hold_left = 0;
    bit stall_next;
    forever begin
      @(posedge clk);
      if (!rst && pix_valid && !pix_stall) pix_sb.check_pixel(pix_word);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        pick_stall_run(stall_next, run_left);
        pix_stall <= stall_next;
      end
    end
  end

  initial begin : stimulus
    logic [PIXEL_W-1:0] corner_pix [6];
    int                 phase_no;
    corner_pix = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a 2 x 3 frame. A fetch with no frame loaded gives
    // nothing; then a full load with extreme pixel values and a fetch of the
    // whole frame plus one more, which must wrap back to the first pixel.
    write_reg(REG_HEIGHT, 8'd2);
    write_reg(REG_WIDTH, 8'd3);
    write_reg(REG_SHIFT_Y, 8'd0);
    write_reg(REG_SHIFT_X, 8'd0);
    send_cmd(CMD_FETCH, 8'h5A);
    foreach (corner_pix[i]) send_cmd(CMD_LOAD, corner_pix[i]);
    repeat (7) send_cmd(CMD_FETCH, PIXEL_W'($urandom_range(0, 255)));

    // Shift down one and left one: the top row and right column go black.
    wait_idle();
    write_reg(REG_SHIFT_Y, 8'd1);
    write_reg(REG_SHIFT_X, 8'hFF);
    repeat (6) send_cmd(CMD_FETCH, PIXEL_W'($urandom_range(0, 255)));

    // Most negative and most positive shifts give black pixels only. Then a
    // load on the ready frame starts a new frame, so the next fetch is idle.
    wait_idle();
    write_reg(REG_SHIFT_Y, 8'h80);
    write_reg(REG_SHIFT_X, 8'h7F);
    repeat (3) send_cmd(CMD_FETCH, PIXEL_W'($urandom_range(0, 255)));
    send_cmd(CMD_LOAD, 8'h3C);
    send_cmd(CMD_FETCH, 8'hC3);

    // Random phases, phases 4 and 9 with a long receiver hold-off, and one
    // full height frame at the end.
    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      run_phase(1'b0, phase_no == 4 || phase_no == 9);
      phase_no++;
    end
    run_phase(1'b1, 1'b0);

    wait_idle();
    if (pix_sb.errors == 0 && pix_sb.pending() == 0) begin
      $display("PASS image_translate_zero_fill_core");
    end else begin
      $display("FAIL image_translate_zero_fill_core");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #20000000;
    $display("FAIL image_translate_zero_fill_core");
    $finish;
  end

endmodule
